[hdl/tti_pkg.sv]
// tti_pkg: shared types and constants for the thermistor table interpolator.
// Holds the resistance table, result/status types and datapath widths.
// No dependencies.
`default_nettype none

package tti_pkg;

	localparam int STORED_ENTRIES = 32;
	localparam int OHM_W          = 18;   // whole ohms, largest entry 189726
	localparam int RES_W          = 24;   // Q20.4 resistance
	localparam int TEMP_W         = 18;   // Q10.8 temperature
	localparam int ALU_W          = 25;   // shared subtractor width
	localparam int DEN_W          = 16;   // neighbor difference, max 57634
	localparam int DIFF_W         = 20;   // r - 16*hi, at most 16*den
	localparam int NUM_W          = 28;   // 160 * diff
	localparam int QUO_W          = 12;   // quotient, at most 2560
	localparam int TBL_IDX_W      = 5;

	localparam logic [TEMP_W-1:0] TEMP_COLD = TEMP_W'(-5120);

	// Descending resistance in ohms, one entry per 10 F from -20 F.
	localparam logic [OHM_W-1:0] OHM_TABLE [STORED_ENTRIES] = '{
		18'd189726, 18'd132092, 18'd93425, 18'd67059, 18'd48804, 18'd35983,
		18'd26855,  18'd20274,  18'd15473, 18'd11929, 18'd9287,  18'd7295,
		18'd5781,   18'd4618,   18'd3718,  18'd3016,  18'd2463,  18'd2025,
		18'd1675,   18'd1395,   18'd1167,  18'd983,   18'd832,   18'd707,
		18'd604,    18'd519,    18'd447,   18'd387,   18'd336,   18'd294,
		18'd257,    18'd226
	};

	typedef enum logic [1:0] {
		CLAMP_NONE = 2'd0,
		CLAMP_COLD = 2'd1,
		CLAMP_HOT  = 2'd2
	} clamp_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temp;
		clamp_t            status;
	} result_t;

endpackage

`default_nettype wire

[hdl/tti_sub.sv]
// tti_sub: the shared subtractor used for table compares and divide steps.
// Depends on tti_pkg for the operand width.
`default_nettype none

module tti_sub (
	input  wire logic [tti_pkg::ALU_W-1:0] a,
	input  wire logic [tti_pkg::ALU_W-1:0] b,
	output logic      [tti_pkg::ALU_W-1:0] diff,
	output logic                           borrow
);

	// borrow set means a < b
	assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

`default_nettype wire

[hdl/tti_ctrl.sv]
// tti_ctrl: sequencer and working registers for scan, setup and serial divide.
// Depends on tti_pkg and drives one tti_sub instance.
`default_nettype none

module tti_ctrl #(
	parameter int TABLE_ENTRIES = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [tti_pkg::RES_W-1:0]     resistance,
	input  wire logic                          take,
	output logic                               idle,
	output logic                               done,
	output tti_pkg::result_t                   result
);

	localparam int SCAN_N = (TABLE_ENTRIES > tti_pkg::STORED_ENTRIES) ?
		tti_pkg::STORED_ENTRIES : ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
	localparam int IDX_W = $clog2(SCAN_N);
	localparam int CNT_W = $clog2(tti_pkg::QUO_W);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SCAN_N - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tti_pkg::QUO_W - 1);
	localparam logic [tti_pkg::TEMP_W-1:0] TEMP_HOT =
		tti_pkg::TEMP_W'(-5120 + 2560 * (SCAN_N - 1));

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SCAN = 7'b0000010,
		ST_DEN  = 7'b0000100,
		ST_DIFF = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_FIN  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t                         state_q;
	logic [IDX_W-1:0]               idx_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [tti_pkg::RES_W-1:0]      r_q;
	logic [tti_pkg::DEN_W-1:0]      den_q;
	logic [tti_pkg::DEN_W-1:0]      rem_q;
	logic [tti_pkg::QUO_W-1:0]      quo_q;
	tti_pkg::result_t               res_q;

	logic [tti_pkg::OHM_W-1:0]      ohm_hi;
	logic [tti_pkg::OHM_W-1:0]      ohm_lo;
	logic [tti_pkg::ALU_W-1:0]      op_a;
	logic [tti_pkg::ALU_W-1:0]      op_b;
	logic [tti_pkg::ALU_W-1:0]      alu_diff;
	logic                           alu_borrow;
	logic [tti_pkg::NUM_W-1:0]      num_ext;
	logic [tti_pkg::NUM_W-1:0]      num;
	logic [tti_pkg::QUO_W:0]        quo_up;
	logic [tti_pkg::TEMP_W-1:0]     idx_temp;
	logic [tti_pkg::TEMP_W-1:0]     interp_temp;

	assign ohm_hi = tti_pkg::OHM_TABLE[tti_pkg::TBL_IDX_W'(idx_q)];
	assign ohm_lo = tti_pkg::OHM_TABLE[tti_pkg::TBL_IDX_W'(idx_q - IDX_W'(1))];

	// operand select for the shared subtractor
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			ST_SCAN: begin
				op_a = tti_pkg::ALU_W'({ohm_hi, 4'b0000});
				op_b = tti_pkg::ALU_W'(r_q);
			end
			ST_DEN: begin
				op_a = tti_pkg::ALU_W'(ohm_lo);
				op_b = tti_pkg::ALU_W'(ohm_hi);
			end
			ST_DIFF: begin
				op_a = tti_pkg::ALU_W'(r_q);
				op_b = tti_pkg::ALU_W'({ohm_hi, 4'b0000});
			end
			ST_DIV: begin
				op_a = tti_pkg::ALU_W'({rem_q, quo_q[tti_pkg::QUO_W-1]});
				op_b = tti_pkg::ALU_W'(den_q);
			end
			ST_IDLE, ST_FIN, ST_DONE: begin
				op_a = '0;
				op_b = '0;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	tti_sub u_sub (
		.a      (op_a),
		.b      (op_b),
		.diff   (alu_diff),
		.borrow (alu_borrow)
	);

	// 160*d as two shifted adds
	assign num_ext = tti_pkg::NUM_W'(alu_diff[tti_pkg::DIFF_W-1:0]);
	assign num     = (num_ext << 7) + (num_ext << 5);

	// round quotient up, then 2560*i - 5120 - q
	assign quo_up      = {1'b0, quo_q} + (tti_pkg::QUO_W+1)'(rem_q != '0);
	assign idx_temp    = (tti_pkg::TEMP_W'(idx_q) << 11) + (tti_pkg::TEMP_W'(idx_q) << 9);
	assign interp_temp = idx_temp + tti_pkg::TEMP_COLD - tti_pkg::TEMP_W'(quo_up);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (alu_borrow) begin
						state_q <= (idx_q == '0) ? ST_DONE : ST_DEN;
					end else if (idx_q == IDX_LAST) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DEN: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			r_q <= resistance;
		end
		if (state_q == ST_SCAN) begin
			if (alu_borrow && idx_q == '0) begin
				res_q.temp   <= tti_pkg::TEMP_COLD;
				res_q.status <= tti_pkg::CLAMP_COLD;
			end else if (!alu_borrow && idx_q == IDX_LAST) begin
				res_q.temp   <= TEMP_HOT;
				res_q.status <= tti_pkg::CLAMP_HOT;
			end
		end
		if (state_q == ST_DEN) begin
			den_q <= alu_diff[tti_pkg::DEN_W-1:0];
		end
		if (state_q == ST_DIFF) begin
			// upper part is below den, so 12 steps cover the quotient
			rem_q <= num[tti_pkg::NUM_W-1:tti_pkg::QUO_W];
			quo_q <= num[tti_pkg::QUO_W-1:0];
		end
		if (state_q == ST_DIV) begin
			rem_q <= alu_borrow ? op_a[tti_pkg::DEN_W-1:0] : alu_diff[tti_pkg::DEN_W-1:0];
			quo_q <= {quo_q[tti_pkg::QUO_W-2:0], ~alu_borrow};
		end
		if (state_q == ST_FIN) begin
			res_q.temp   <= interp_temp;
			res_q.status <= tti_pkg::CLAMP_NONE;
		end
	end

	assign idle   = (state_q == ST_IDLE);
	assign done   = (state_q == ST_DONE);
	assign result = res_q;

endmodule

`default_nettype wire

[hdl/thermistor_table_interpolator_unit.sv]
// thermistor_table_interpolator_unit: top level, thermistor resistance to temperature.
// Depends on tti_pkg, tti_ctrl and tti_sub.
//
//   channel | signals                                   | direction | content
//   --------+-------------------------------------------+-----------+-------------------------
//   in      | in_valid, in_stall, resistance_q4         | to block  | Q20.4 ohms, unsigned
//   out     | out_valid, out_stall, temp_q8, clamp_status| from block| Q10.8 deg F, clamp code
//
// Sequence: one scan step per table entry up to the hit (at most N, 32 by default), then
// setup, the 12-step restoring divide and the final sum, then done and back to idle; a cold
// clamp ends at the first entry, a hot clamp at the last; one shared subtractor does all.
// Reset: arst_n clears the sequencer and the output valid; no table init needed.
// Stalls: the result waits in the output register while the core takes the next
// input transaction; in_stall is high whenever the core is busy.
`default_nettype none

module thermistor_table_interpolator_unit #(
	parameter int TABLE_ENTRIES = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [tti_pkg::RES_W-1:0]     resistance_q4,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [tti_pkg::TEMP_W-1:0]  temp_q8,
	output logic [1:0]                         clamp_status
);

	logic             core_idle;
	logic             core_done;
	logic             take;
	tti_pkg::result_t core_res;
	tti_pkg::result_t out_q;
	logic             out_valid_q;

	// output register is free when empty or being drained this cycle
	assign take = core_done && (!out_valid_q || !out_stall);

	tti_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_valid),
		.resistance (resistance_q4),
		.take       (take),
		.idle       (core_idle),
		.done       (core_done),
		.result     (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= core_res;
		end
	end

	assign in_stall     = !core_idle;
	assign out_valid    = out_valid_q;
	assign temp_q8      = $signed(out_q.temp);
	assign clamp_status = out_q.status;

endmodule

`default_nettype wire
